>>> rtl/box_downscale_8x8_assert.svh
// Assertion macros for the 8x8 box downscaler.
// Expects clk and arst_n in the scope of each use.
`ifndef BOX_DOWNSCALE_8X8_ASSERT_SVH
`define BOX_DOWNSCALE_8X8_ASSERT_SVH

// Same-cycle implication.
`define BDS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BDS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bds_pkg.sv
// Shared types and constants of the 8x8 box downscaler.
// No dependencies.
`timescale 1ns / 1ps

package bds_pkg;
	localparam int unsigned DEF_OUT_COLUMNS = 128;
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned SUM_W = 11;
	localparam int unsigned AVG_SHIFT = 3;
	localparam int unsigned CNT_W = 3;

	localparam logic [CNT_W-1:0] GROUP_LAST = 3'd7;
	localparam logic [CNT_W-1:0] LINE_LAST = 3'd7;

	localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LINE_END = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FRAME = 2'd2;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_LINE = 2'd1,
		KIND_FRAME = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [PIX_W-1:0] pixel;
	} result_t;
endpackage

>>> rtl/bds_in_if.sv
// Input channel of the 8x8 box downscaler: pixel and raster events.
// Depends on bds_pkg.
`timescale 1ns / 1ps

interface bds_in_if import bds_pkg::*; ();
	logic valid;
	logic ready;
	logic [FUNC_W-1:0] func;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, func, pixel_value, input ready);
	modport sink (input valid, func, pixel_value, output ready);
endinterface

>>> rtl/bds_out_if.sv
// Output channel of the 8x8 box downscaler: averaged pixels and markers.
// Depends on bds_pkg.
`timescale 1ns / 1ps

interface bds_out_if import bds_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] out_kind;
	logic [PIX_W-1:0] out_pixel;

	modport source (output valid, out_kind, out_pixel, input ready);
	modport sink (input valid, out_kind, out_pixel, output ready);
endinterface

>>> rtl/box_downscale_8x8.sv
// Top level of the 8x8 box downscaler: counters, column line store, output queue.
// Depends on bds_pkg, bds_in_if, bds_out_if and box_downscale_8x8_assert.svh.
`timescale 1ns / 1ps

// Takes one transaction per clock while ready is high; results are registered, then queued.
// Every in-range eighth pixel of a line read-modify-writes one line store entry: the
// read is issued when the pixel is taken, the add and write-back happen in the next
// cycle, so the single-read, single-write store keeps pace at one item per cycle.
// Results wait in a four-entry output queue; ready drops only while that queue and
// the result in flight would fill it. The store needs no clearing after reset.
module box_downscale_8x8 import bds_pkg::*; #(
	parameter int unsigned OUT_COLUMNS = DEF_OUT_COLUMNS
) (
	input logic clk,
	input logic arst_n,
	bds_in_if.sink pix_in,
	bds_out_if.source pix_out
);
	localparam int unsigned CW = $clog2(OUT_COLUMNS + 1);
	localparam int unsigned AW = (OUT_COLUMNS > 1) ? $clog2(OUT_COLUMNS) : 1;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FAW = 2;
	localparam int unsigned FCW = 3;

	logic accept;
	logic is_pix, is_line, is_frame;
	logic [CNT_W-1:0] pig_q, line_q;
	logic [SUM_W-1:0] row_sum_q, row_next;
	logic [CW-1:0] col_q;
	logic in_range, rd_en, emit_in;
	logic [AW-1:0] rd_addr;
	kind_t kind_in;

	logic [SUM_W-1:0] mem [OUT_COLUMNS];

	logic op_s1, emit_s1, first_s1;
	kind_t kind_s1;
	logic [PIX_W-1:0] avg_s1;
	logic [AW-1:0] addr_s1;
	logic [SUM_W-1:0] rdata_s1, total;
	result_t res_s1;

	result_t fifo_q [FIFO_DEPTH];
	logic [FAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCW-1:0] cnt_q;
	logic pop;

	assign is_pix = pix_in.func == FUNC_PIXEL;
	assign is_line = pix_in.func == FUNC_LINE_END;
	assign is_frame = pix_in.func == FUNC_FRAME;
	assign accept = pix_in.valid && pix_in.ready;
	assign pix_in.ready = (cnt_q + FCW'(emit_s1)) < FCW'(FIFO_DEPTH);

	assign row_next = row_sum_q + SUM_W'(pix_in.pixel_value);
	assign in_range = col_q < CW'(OUT_COLUMNS);
	assign rd_addr = col_q[AW-1:0];
	assign rd_en = accept && is_pix && (pig_q == GROUP_LAST) && in_range;

	always_comb begin
		kind_in = KIND_PIXEL;
		emit_in = 1'b0;
		if (rd_en && line_q == LINE_LAST) begin
			emit_in = 1'b1;
		end else if (accept && is_line && line_q == LINE_LAST) begin
			kind_in = KIND_LINE;
			emit_in = 1'b1;
		end else if (accept && is_frame) begin
			kind_in = KIND_FRAME;
			emit_in = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pig_q <= '0;
			line_q <= '0;
			row_sum_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (is_pix) begin
				pig_q <= pig_q + 1'b1;
				if (pig_q == '0) begin
					row_sum_q <= SUM_W'(pix_in.pixel_value);
				end else if (pig_q != GROUP_LAST) begin
					row_sum_q <= row_next;
				end else if (in_range) begin
					col_q <= col_q + 1'b1;
				end
			end else if (is_line) begin
				pig_q <= '0;
				col_q <= '0;
				if (line_q == LINE_LAST) begin
					line_q <= '0;
					row_sum_q <= '0;
				end else begin
					line_q <= line_q + 1'b1;
				end
			end else if (is_frame) begin
				pig_q <= '0;
				line_q <= '0;
				col_q <= '0;
				row_sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			op_s1 <= rd_en;
			emit_s1 <= emit_in;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind_in;
		first_s1 <= line_q == '0;
		avg_s1 <= row_next[SUM_W-1:AVG_SHIFT];
		addr_s1 <= rd_addr;
	end

	// Line store: read on the eighth pixel, write back in the next cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		if (op_s1) begin
			mem[addr_s1] <= total;
		end
	end

	assign total = first_s1 ? SUM_W'(avg_s1) : SUM_W'(avg_s1) + rdata_s1;

	always_comb begin
		res_s1.kind = kind_s1;
		res_s1.pixel = (kind_s1 == KIND_PIXEL) ? total[SUM_W-1:AVG_SHIFT] : '0;
	end

	assign pop = pix_out.valid && pix_out.ready;
	assign pix_out.valid = cnt_q != '0;
	assign pix_out.out_kind = fifo_q[rd_ptr_q].kind;
	assign pix_out.out_pixel = fifo_q[rd_ptr_q].pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (emit_s1) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FCW'(emit_s1) - FCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (emit_s1) begin
			fifo_q[wr_ptr_q] <= res_s1;
		end
	end

`include "box_downscale_8x8_assert.svh"

	`BDS_ASSERT_IMP(a_queue_bound, 1'b1, cnt_q <= FCW'(FIFO_DEPTH), "output queue count out of range")
	`BDS_ASSERT_IMP(a_no_overflow, emit_s1, (cnt_q < FCW'(FIFO_DEPTH)) || pop, "result pushed into full queue")
	`BDS_ASSERT_IMP(a_ports_apart, rd_en && op_s1, rd_addr != addr_s1, "line store read and write hit one entry")
	`BDS_ASSERT_NXT(a_rmw_follows, rd_en, op_s1, "line store read without write-back")
	`BDS_ASSERT_IMP(a_marker_zero, pix_out.valid && pix_out.out_kind != KIND_PIXEL, pix_out.out_pixel == '0, "marker carries nonzero pixel")

endmodule
